>>> rtl/dwt_pkg.sv
`default_nettype none

package dwt_pkg;

  // Depth values and the signed width used for sums and differences of them.
  localparam int unsigned DEPTH_BITS = 16;
  localparam int unsigned CALC_BITS  = DEPTH_BITS + 2;
  localparam int unsigned SPAN_BITS  = 15;
  localparam int unsigned HALF_BITS  = 14;
  localparam int unsigned CFG_IDX_BITS = 3;

  typedef logic signed [DEPTH_BITS-1:0] depth_t;
  typedef logic signed [CALC_BITS-1:0]  calc_t;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ACTIVE_THRESHOLD = 3'd0,
    CFG_UPPER_LIMIT      = 3'd1,
    CFG_LOWER_LIMIT      = 3'd2,
    CFG_WINDOW_SPAN      = 3'd3,
    CFG_HALF_SPAN        = 3'd4
  } cfg_reg_e;

  // Clamp a wide signed value to the depth range.
  function automatic depth_t sat_depth(input calc_t v);
    calc_t hi;
    calc_t lo;
    hi = calc_t'({1'b0, {(DEPTH_BITS-1){1'b1}}});
    lo = -hi - calc_t'(1);
    if (v > hi) begin
      sat_depth = hi[DEPTH_BITS-1:0];
    end else if (v < lo) begin
      sat_depth = lo[DEPTH_BITS-1:0];
    end else begin
      sat_depth = v[DEPTH_BITS-1:0];
    end
  endfunction

  // Floor of the midpoint of two depths: an arithmetic shift of the sum.
  function automatic depth_t mean_of(input depth_t a, input depth_t b);
    calc_t sum;
    sum = calc_t'(a) + calc_t'(b);
    mean_of = sum[DEPTH_BITS:1];
  endfunction

endpackage

`default_nettype wire

>>> rtl/depth_window_tracker_core.sv
`default_nettype none

// Channel    Direction  Handshake              Payload
// cfg        in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
// in         in         in_valid_i/in_stall_o   depth_sample_i
// out        out        out_valid_o/out_stall_i observer_depth_o, flags
//
// One sample beat is accepted per cycle while the input is not stalled. Its result
// is written into the result register as the sample leaves the input register,
// and it leaves the result register when the output is not stalled.
// The window and held estimate update as a sample leaves the input register,
// so the state loop sets the rate of one beat per cycle while the output is not stalled.
// Reset clears the tracking state and loads the register defaults.
// A stalled output holds the result register; the input register still takes
// a beat while it is empty, then stalls upstream.
module depth_window_tracker_core
  import dwt_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [DEPTH_BITS-1:0]    cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [DEPTH_BITS-1:0] depth_sample_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [DEPTH_BITS-1:0]  observer_depth_o,
  output logic                          tracking_active_o,
  output logic                          above_limit_o,
  output logic                          below_limit_o,
  output logic                          snapped_to_mean_o
);

  // Configuration registers.
  depth_t               thr_q, upper_q, lower_q;
  logic [SPAN_BITS-1:0] span_q;
  logic [HALF_BITS-1:0] half_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      upper_q <= {1'b0, {(DEPTH_BITS-1){1'b1}}};
      lower_q <= {1'b1, {(DEPTH_BITS-1){1'b0}}};
      span_q  <= SPAN_BITS'(1000);
      half_q  <= HALF_BITS'(500);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_ACTIVE_THRESHOLD: thr_q   <= cfg_data_i;
        CFG_UPPER_LIMIT:      upper_q <= cfg_data_i;
        CFG_LOWER_LIMIT:      lower_q <= cfg_data_i;
        CFG_WINDOW_SPAN:      span_q  <= cfg_data_i[SPAN_BITS-1:0];
        CFG_HALF_SPAN:        half_q  <= cfg_data_i[HALF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input register and handshake.
  logic   s1_valid_q;
  depth_t s1_sample_q;
  logic   advance;

  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_sample_q <= depth_sample_i;
    end
  end

  // Tracking state.
  logic   active_q, active_d;
  depth_t wh_q, wh_d, wl_q, wl_d, held_q, held_d;
  logic   above, below, snapped;

  // Widened copies of the sample and the spans.
  calc_t s_x, span_x, half_x;
  assign s_x    = calc_t'(s1_sample_q);
  assign span_x = signed'(CALC_BITS'(span_q));
  assign half_x = signed'(CALC_BITS'(half_q));

  // Window on entry: opened around the sample on the first active beat.
  depth_t wh0, wl0, held0, mean;
  calc_t  width, diff;

  always_comb begin
    wh0     = active_q ? wh_q : sat_depth(s_x + half_x);
    wl0     = active_q ? wl_q : sat_depth(s_x - half_x);
    held0   = active_q ? held_q : mean_of(wh0, wl0);
    active_d = active_q;
    wh_d    = wh_q;
    wl_d    = wl_q;
    held_d  = held_q;
    above   = 1'b0;
    below   = 1'b0;
    snapped = 1'b0;
    width   = '0;
    mean    = '0;
    diff    = '0;
    if (s1_sample_q > thr_q) begin
      // Above threshold: tracking off, window cleared, estimate kept.
      active_d = 1'b0;
      wh_d     = '0;
      wl_d     = '0;
    end else begin
      active_d = 1'b1;
      wh_d     = wh0;
      wl_d     = wl0;
      // Stretch the window toward an in-limit sample, then cap its width.
      if (s1_sample_q > upper_q) begin
        above = 1'b1;
      end else if (s1_sample_q > wh0) begin
        wh_d  = s1_sample_q;
        width = s_x - calc_t'(wl0);
        if (width > span_x) begin
          wl_d = sat_depth(s_x - span_x);
        end
      end else if (s1_sample_q < lower_q) begin
        below = 1'b1;
      end else if (s1_sample_q < wl0) begin
        wl_d  = s1_sample_q;
        width = calc_t'(wh0) - s_x;
        if (width > span_x) begin
          wh_d = sat_depth(s_x + span_x);
        end
      end
      // Snap the estimate to the mean, or to an edge when it drifts off.
      mean = mean_of(wh_d, wl_d);
      diff = calc_t'(held0) - calc_t'(mean);
      if (diff < 0) begin
        diff = -diff;
      end
      held_d = held0;
      if (diff > span_x) begin
        held_d  = mean;
        snapped = 1'b1;
      end else if (calc_t'(held0) > calc_t'(mean) + half_x) begin
        held_d = wh_d;
      end else if (calc_t'(held0) < calc_t'(mean) - half_x) begin
        held_d = wl_d;
      end
    end
  end

  logic fire;
  assign fire = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      wh_q     <= '0;
      wl_q     <= '0;
      held_q   <= '0;
    end else if (fire) begin
      active_q <= active_d;
      wh_q     <= wh_d;
      wl_q     <= wl_d;
      held_q   <= held_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      observer_depth_o  <= held_d;
      tracking_active_o <= active_d;
      above_limit_o     <= above;
      below_limit_o     <= below;
      snapped_to_mean_o <= snapped;
    end
  end

  // An idle tracker keeps an empty window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (wh_q == '0 && wl_q == '0))
    else $error("inactive tracker holds a nonempty window");

  // The window never inverts while tracking.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (wh_q >= wl_q))
    else $error("window top below window bottom");

  // A sample cannot be flagged on both sides.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(above_limit_o && below_limit_o))
    else $error("sample flagged above and below the limits");

  // Flags are only raised while tracking.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !tracking_active_o)
      |-> !(above_limit_o || below_limit_o || snapped_to_mean_o))
    else $error("flag raised while tracking is inactive");

  // The tracking state moves only when a beat leaves the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> ($stable(active_q) && $stable(held_q)))
    else $error("tracking state changed without a beat");

endmodule

`default_nettype wire

>>> bench/depth_window_tracker_core_tb.sv
`default_nettype none

module depth_window_tracker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dwt_pkg::*;

  localparam int IDLE_LIMIT    = 5000;
  localparam int DRAIN_CYCLES  = 4;
  localparam int RANDOM_PHASES = 12;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef struct packed {
    depth_t depth;
    logic   active;
    logic   above;
    logic   below;
    logic   snapped;
  } depth_result_t;

  // Tracks the window and held estimate beside the block and checks each result beat.
  class observer_scoreboard;
    int threshold_mm;
    int upper_mm;
    int lower_mm;
    int span_mm;
    int half_mm;
    bit tracking;
    int win_high;
    int win_low;
    int held_mm;
    depth_result_t expected_depths[$];
    int samples_noted;
    int results_checked;
    int mismatches;
    int snaps;
    int flagged;

    function new();
      threshold_mm = 0;
      upper_mm = 32767;
      lower_mm = -32768;
      span_mm = 1000;
      half_mm = 500;
      tracking = 1'b0;
      win_high = 0;
      win_low = 0;
      held_mm = 0;
      samples_noted = 0;
      results_checked = 0;
      mismatches = 0;
      snaps = 0;
      flagged = 0;
    endfunction

    static function int clamp_mm(int v);
      if (v > 32767) begin
        return 32767;
      end
      if (v < -32768) begin
        return -32768;
      end
      return v;
    endfunction

    function void write_register(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] data);
      case (idx)
        CFG_ACTIVE_THRESHOLD: threshold_mm = int'(depth_t'(data));
        CFG_UPPER_LIMIT:      upper_mm = int'(depth_t'(data));
        CFG_LOWER_LIMIT:      lower_mm = int'(depth_t'(data));
        CFG_WINDOW_SPAN:      span_mm = int'(data[SPAN_BITS-1:0]);
        CFG_HALF_SPAN:        half_mm = int'(data[HALF_BITS-1:0]);
        default: ;
      endcase
    endfunction

    // Advance the window for one sample and queue the result it should produce.
    function void note_sample(depth_t sample);
      int s;
      int mean;
      int diff;
      depth_result_t res;
      s = int'(sample);
      res = '0;
      if (s > threshold_mm) begin
        tracking = 1'b0;
        win_high = 0;
        win_low = 0;
      end else begin
        if (!tracking) begin
          tracking = 1'b1;
          win_high = clamp_mm(s + half_mm);
          win_low = clamp_mm(s - half_mm);
          held_mm = (win_high + win_low) >>> 1;
        end
        // The upper limit is tested first, so a sample above it never counts as low.
        if (s > upper_mm) begin
          res.above = 1'b1;
        end else if (s > win_high) begin
          win_high = clamp_mm(s);
          if (win_high - win_low > span_mm) begin
            win_low = clamp_mm(win_high - span_mm);
          end
        end else if (s < lower_mm) begin
          res.below = 1'b1;
        end else if (s < win_low) begin
          win_low = clamp_mm(s);
          if (win_high - win_low > span_mm) begin
            win_high = clamp_mm(win_low + span_mm);
          end
        end
        mean = (win_high + win_low) >>> 1;
        diff = held_mm - mean;
        if (diff < 0) begin
          diff = -diff;
        end
        if (diff > span_mm) begin
          held_mm = mean;
          res.snapped = 1'b1;
        end else if (held_mm > mean + half_mm) begin
          held_mm = win_high;
        end else if (held_mm < mean - half_mm) begin
          held_mm = win_low;
        end
      end
      res.depth = depth_t'(held_mm);
      res.active = tracking;
      expected_depths.push_back(res);
      samples_noted++;
    endfunction

    function void check_result(depth_result_t got);
      depth_result_t want;
      results_checked++;
      if (expected_depths.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result beat with no sample outstanding: depth %0d flags %b%b%b%b",
                   $time, $signed(got.depth), got.active, got.above, got.below, got.snapped);
        end
        return;
      end
      want = expected_depths.pop_front();
      if (want.snapped) begin
        snaps++;
      end
      if (want.above || want.below) begin
        flagged++;
      end
      if (got.depth !== want.depth || got.active !== want.active || got.above !== want.above
          || got.below !== want.below || got.snapped !== want.snapped) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: expected depth %0d active %b above %b below %b snapped %b", $time,
                   $signed(want.depth), want.active, want.above, want.below, want.snapped);
          $display("%0t:   actual depth %0d active %b above %b below %b snapped %b", $time,
                   $signed(got.depth), got.active, got.above, got.below, got.snapped);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [DEPTH_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  depth_t depth_sample = '0;
  logic out_stall = 1'b0;
  logic steady = 1'b1;
  logic cfg_ready_o;
  logic in_stall_o;
  logic out_valid_o;
  logic signed [15:0] observer_depth_o;
  logic tracking_active_o;
  logic above_limit_o;
  logic below_limit_o;
  logic snapped_to_mean_o;

  observer_scoreboard depth_board = new();
  int stall_left = 0;
  int idle_cycles = 0;

  always #1ns clk_i = ~clk_i;

  depth_window_tracker_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .depth_sample_i    (depth_sample),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .observer_depth_o  (observer_depth_o),
    .tracking_active_o (tracking_active_o),
    .above_limit_o     (above_limit_o),
    .below_limit_o     (below_limit_o),
    .snapped_to_mean_o (snapped_to_mean_o)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  // A register value in range, with the two ends picked more often.
  function automatic int pick_cfg(int lo_v, int hi_v);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) begin
      return lo_v;
    end
    if (r == 1) begin
      return hi_v;
    end
    return lo_v + int'($urandom_range(0, hi_v - lo_v));
  endfunction

  // Output side stalls in random runs, except in steady stretches.
  always @(posedge clk_i) begin
    if (!rst_ni || steady) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      stall_left = ($urandom_range(0, 99) < 25) ? pick_gap() : 0;
      out_stall <= (stall_left > 0);
      if (stall_left > 0) begin
        stall_left--;
      end
    end
  end

  // Sample the handshakes mid-cycle, where every signal has settled for the next edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        depth_board.check_result(depth_result_t'{observer_depth_o, tracking_active_o,
                                                 above_limit_o, below_limit_o,
                                                 snapped_to_mean_o});
      end
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)
          || (cfg_valid && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("No beat moved for %0d cycles, giving up.", IDLE_LIMIT);
        $display("depth_window_tracker_core_tb failed");
        $finish;
      end
    end
  end

  // Present one sample beat and return at the edge that takes it.
  task automatic send_sample(input depth_t sample);
    logic taken;
    in_valid <= 1'b1;
    depth_sample <= sample;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    depth_board.note_sample(sample);
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Leaves cfg_valid high so back-to-back writes need no extra assignment.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] data);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    depth_board.write_register(idx, data);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (depth_board.expected_depths.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_config(input int thr, input int up, input int lo, input int span,
                              input int half);
    drain_results();
    write_reg(CFG_ACTIVE_THRESHOLD, 16'(thr));
    write_reg(CFG_UPPER_LIMIT, 16'(up));
    write_reg(CFG_LOWER_LIMIT, 16'(lo));
    write_reg(CFG_WINDOW_SPAN, 16'(span));
    write_reg(CFG_HALF_SPAN, 16'(half));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int thr;
    int up;
    int lo;
    int span;
    int half;
    int walk;
    int step;
    int sample;
    int count;
    int phase;
    int k;
    bit calm;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A write to an unmapped index must leave the reset settings alone.
    write_reg(CFG_UNUSED_IDX, 16'h7FFF);
    cfg_valid <= 1'b0;

    // Reset settings: inactive top sample, activation at the bottom with saturation,
    // stretching down past the span, deactivation and reactivation at the threshold.
    send_sample(32767);
    send_sample(-32768);
    send_sample(-32768);
    send_sample(0);
    send_sample(-700);
    send_sample(-2000);
    send_sample(-1);
    send_sample(1);
    send_sample(0);

    // Zero spans, tight limits and a threshold that nothing can exceed.
    apply_config(32767, 1000, -1000, 0, 0);
    send_sample(2000);
    send_sample(-2000);
    send_sample(300);
    send_sample(-300);
    send_sample(32767);
    send_sample(-32768);

    // Crossed limits with the widest spans.
    apply_config(32767, -100, 100, 32767, 16383);
    send_sample(0);
    send_sample(-200);
    send_sample(32767);
    send_sample(-32768);

    // Lowest threshold: only the most negative sample keeps tracking on.
    apply_config(-32768, 32767, -32768, 32767, 16383);
    send_sample(0);
    send_sample(-32768);
    send_sample(-32768);
    send_sample(5);

    // Random settings, each followed by a random walk of samples near the threshold.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      thr = pick_cfg(-32768, 32767);
      up = ($urandom_range(0, 3) == 0) ? pick_cfg(-32768, 32767)
           : observer_scoreboard::clamp_mm(thr - int'($urandom_range(0, 3000)));
      lo = ($urandom_range(0, 3) == 0) ? pick_cfg(-32768, 32767)
           : observer_scoreboard::clamp_mm(up - int'($urandom_range(0, 6000)));
      span = $urandom_range(0, 1) ? pick_cfg(0, 32767) : int'($urandom_range(0, 3000));
      half = $urandom_range(0, 1) ? pick_cfg(0, 16383) : int'($urandom_range(0, 1500));
      apply_config(thr, up, lo, span, half);

      calm = ($urandom_range(0, 3) == 0);
      steady <= calm;
      case ($urandom_range(0, 2))
        0: step = 20;
        1: step = span / 2 + 1;
        default: step = 2000;
      endcase
      walk = observer_scoreboard::clamp_mm(thr - half);
      count = $urandom_range(130, 190);

      for (k = 0; k < count; k++) begin
        case ($urandom_range(0, 99)) inside
          [0:7]: sample = int'($urandom_range(0, 65535)) - 32768;
          [8:14]: begin
            case ($urandom_range(0, 7))
              0: sample = -32768;
              1: sample = 32767;
              2: sample = thr;
              3: sample = thr + 1;
              4: sample = up;
              5: sample = up + 1;
              6: sample = lo;
              default: sample = lo - 1;
            endcase
          end
          default: begin
            // Drift back down once the walk has left the active range.
            walk = observer_scoreboard::clamp_mm(walk + int'($urandom_range(0, 2 * step))
                                                 - step - ((walk > thr) ? step / 2 : 0));
            sample = walk;
          end
        endcase
        send_sample(depth_t'(observer_scoreboard::clamp_mm(sample)));
        if (!calm) begin
          pause_sender(pick_gap());
        end
      end
    end

    drain_results();
    $display("Checked %0d observer results from %0d depth samples over %0d register settings.",
             depth_board.results_checked, depth_board.samples_noted, RANDOM_PHASES + 4);
    $display("Snaps to window mean: %0d, samples outside the limits: %0d, mismatches: %0d.",
             depth_board.snaps, depth_board.flagged, depth_board.mismatches);
    if (depth_board.mismatches == 0 && depth_board.expected_depths.size() == 0) begin
      $display("depth_window_tracker_core_tb passed");
    end else begin
      $display("depth_window_tracker_core_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
